// File: rtl/core/fat_cluster_chain_allocator_defines.svh
// Assertion macros used by the allocation table top level.
`ifndef FAT_CLUSTER_CHAIN_ALLOCATOR_DEFINES_SVH
`define FAT_CLUSTER_CHAIN_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FCCA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FCCA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/fcca_pkg.sv
// Types, constants and codes shared by the allocation table modules.
package fcca_pkg;

	localparam int          TABLE_ENTRIES_DEF = 4096;
	localparam logic [31:0] END_MARKER_DEF    = 32'h0FFF_FFFF;

	localparam int CLUSTER_W = 12;
	localparam int LENGTH_W  = 13;
	localparam int VALUE_W   = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [CLUSTER_W-1:0] SCAN_START_RST   = 12'd1;
	localparam logic [LENGTH_W-1:0]  TABLE_LENGTH_RST = 13'd4096;

	localparam logic [CFG_IDX_W-1:0] CFG_SCAN_START   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 2'd1;

	typedef enum logic [1:0] {
		REQ_CREATE = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_GET    = 2'd2,
		REQ_PUT    = 2'd3
	} req_e_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_FREE  = 2'd1,
		ST_NOT_END  = 2'd2,
		ST_PRED_BAD = 2'd3
	} status_e_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_TAIL,
		S_SCAN,
		S_LINK,
		S_PREV,
		S_WALK,
		S_GET
	} state_e_t;

	typedef struct packed {
		logic [CLUSTER_W-1:0] new_cluster;
		logic [VALUE_W-1:0]   read_value;
		status_e_t            status;
	} result_t;

endpackage

// File: rtl/core/fat_cluster_chain_allocator.sv
// Top level of the cluster chain allocator: configuration registers and sequencer.
//
//  Channel   Handshake                   Payload
//  --------  --------------------------  ------------------------------------------------
//  request   start / busy                req_type, cluster, prev_cluster, entry_value
//  result    done (one-cycle strobe)     new_cluster, read_value, status
//  config    cfg_valid / cfg_ready       cfg_index, cfg_data
//
// A request is taken when start is high and busy is low. Put finishes in the cycle in
// which it is taken, and get reads the entry first; the result strobe follows in the
// next cycle. Create checks the tail entry first when it extends a chain, then searches
// the table from scan_start for a free entry, and when extending links the tail to it.
// Remove checks the predecessor entry first when prev_cluster is nonzero, then frees the
// chain one entry at a time. Each step waits on the single table read port, whose read
// is registered. After reset the block clears the whole table, one entry a cycle, with
// busy high. The result strobe cannot be held off; configuration is always ready.
`include "fat_cluster_chain_allocator_defines.svh"

module fat_cluster_chain_allocator #(
	parameter int          TABLE_ENTRIES = fcca_pkg::TABLE_ENTRIES_DEF,
	parameter logic [31:0] END_MARKER    = fcca_pkg::END_MARKER_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     req_type,
	input  logic [fcca_pkg::CLUSTER_W-1:0] cluster,
	input  logic [fcca_pkg::CLUSTER_W-1:0] prev_cluster,
	input  logic [fcca_pkg::VALUE_W-1:0]   entry_value,
	output logic                           done,
	output logic [fcca_pkg::CLUSTER_W-1:0] new_cluster,
	output logic [fcca_pkg::VALUE_W-1:0]   read_value,
	output logic [1:0]                     status,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fcca_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fcca_pkg::LENGTH_W-1:0]  cfg_data
);
	import fcca_pkg::*;

	logic [CLUSTER_W-1:0] scan_start_q;
	logic [LENGTH_W-1:0]  table_length_q;
	result_t              result;

	// Configuration is taken in every cycle. Writes to unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_start_q   <= SCAN_START_RST;
			table_length_q <= TABLE_LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SCAN_START: begin
					scan_start_q <= cfg_data[CLUSTER_W-1:0];
				end
				CFG_TABLE_LENGTH: begin
					table_length_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// The sequencer owns the table memory and every request's walk through it.
	fcca_ctrl #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.END_MARKER    (END_MARKER)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.cluster      (cluster),
		.prev_cluster (prev_cluster),
		.entry_value  (entry_value),
		.scan_start   (scan_start_q),
		.table_length (table_length_q),
		.done         (done),
		.result       (result)
	);

	assign new_cluster = result.new_cluster;
	assign read_value  = result.read_value;
	assign status      = result.status;

	// Every accepted request either keeps the block busy or reports at once.
	`FCCA_ASSERT_NEXT(a_req_progress, start && !busy, busy || done, "request neither ran nor reported")
	// A result only follows a request that was taken or still running.
	`FCCA_ASSERT_NOW(a_done_cause, done, $past(busy) || $past(start), "result without a request")
	// A failed search never reports an allocated cluster.
	`FCCA_ASSERT_NOW(a_nofree_zero, done && (status == ST_NO_FREE), new_cluster == '0, "cluster on failure")

endmodule

// File: rtl/core/fcca_table_mem.sv
// Table memory: one write port, one read port, registered read with write-first bypass.
module fcca_table_mem #(
	parameter int DEPTH = fcca_pkg::TABLE_ENTRIES_DEF,
	parameter int AW    = $clog2(fcca_pkg::TABLE_ENTRIES_DEF),
	parameter int DW    = fcca_pkg::VALUE_W
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	import fcca_pkg::*;

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// A read of the entry written in the same cycle returns the new value.
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/fcca_ctrl.sv
// Request sequencer: clearing pass, free search, chain walk, get and put.
module fcca_ctrl #(
	parameter int          TABLE_ENTRIES = fcca_pkg::TABLE_ENTRIES_DEF,
	parameter logic [31:0] END_MARKER    = fcca_pkg::END_MARKER_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       req_type,
	input  logic [fcca_pkg::CLUSTER_W-1:0]   cluster,
	input  logic [fcca_pkg::CLUSTER_W-1:0]   prev_cluster,
	input  logic [fcca_pkg::VALUE_W-1:0]     entry_value,
	input  logic [fcca_pkg::CLUSTER_W-1:0]   scan_start,
	input  logic [fcca_pkg::LENGTH_W-1:0]    table_length,
	output logic                             done,
	output fcca_pkg::result_t                result
);
	import fcca_pkg::*;

	localparam int          AW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [31:0] TE_W = 32'(TABLE_ENTRIES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

	state_e_t state_q, state_d;

	logic [CLUSTER_W-1:0] clst_q, pclst_q;
	logic [LENGTH_W-1:0]  scan_q, scan_d;
	logic                 pend_s1, pend_d;
	logic [CLUSTER_W-1:0] pend_addr_s1, pend_addr_d;
	logic [AW-1:0]        walk_q, walk_d;
	logic [CLUSTER_W-1:0] found_q, found_d;
	logic [AW-1:0]        clr_q, clr_d;
	logic                 done_q;
	result_t              res_q;

	logic                 fin;
	result_t              fin_res;
	logic                 accept;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [VALUE_W-1:0]   mem_wdata;
	logic [AW-1:0]        mem_raddr;
	logic [VALUE_W-1:0]   mem_rdata;

	logic [31:0]          cl_w, pcl_w, clq_w, pclq_w, scan_w, pend_w;
	logic                 cl_ok, clq_ok, pclq_ok, nxt_ok;
	logic [LENGTH_W-1:0]  lim;
	logic [VALUE_W-1:0]   tail_val, prev_val;

	assign cl_w   = 32'(cluster);
	assign pcl_w  = 32'(prev_cluster);
	assign clq_w  = 32'(clst_q);
	assign pclq_w = 32'(pclst_q);
	assign scan_w = 32'(scan_q);
	assign pend_w = 32'(pend_addr_s1);

	assign cl_ok   = cl_w < TE_W;
	assign clq_ok  = clq_w < TE_W;
	assign pclq_ok = pclq_w < TE_W;
	assign nxt_ok  = mem_rdata < TE_W;

	// Search limit is the smaller of the register and the table size.
	assign lim = (32'(table_length) < TE_W) ? table_length : TE_W[LENGTH_W-1:0];

	assign tail_val = clq_ok ? mem_rdata : '0;
	assign prev_val = pclq_ok ? mem_rdata : '0;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	fcca_table_mem #(
		.DEPTH (TABLE_ENTRIES),
		.AW    (AW),
		.DW    (VALUE_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			clr_q   <= clr_d;
			pend_s1 <= pend_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			clst_q  <= cluster;
			pclst_q <= prev_cluster;
		end
		scan_q       <= scan_d;
		pend_addr_s1 <= pend_addr_d;
		walk_q       <= walk_d;
		found_q      <= found_d;
		if (fin) begin
			res_q <= fin_res;
		end
	end

	always_comb begin
		state_d     = state_q;
		scan_d      = scan_q;
		pend_d      = pend_s1;
		pend_addr_d = pend_addr_s1;
		walk_d      = walk_q;
		found_d     = found_q;
		clr_d       = clr_q;
		fin         = 1'b0;
		fin_res     = '{new_cluster: '0, read_value: '0, status: ST_OK};
		mem_we      = 1'b0;
		mem_waddr   = '0;
		mem_wdata   = '0;
		mem_raddr   = '0;

		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				clr_d     = clr_q + AW'(1);
				if (clr_q == LAST_ADDR) begin
					state_d = S_IDLE;
				end
			end

			S_IDLE: begin
				if (start) begin
					case (req_e_t'(req_type))
						REQ_CREATE: begin
							if (cluster != '0) begin
								mem_raddr = cl_w[AW-1:0];
								state_d   = S_TAIL;
							end else begin
								scan_d  = 13'(scan_start);
								pend_d  = 1'b0;
								state_d = S_SCAN;
							end
						end
						REQ_REMOVE: begin
							if (prev_cluster != '0) begin
								mem_raddr = pcl_w[AW-1:0];
								state_d   = S_PREV;
							end else if (cl_ok) begin
								mem_raddr = cl_w[AW-1:0];
								walk_d    = cl_w[AW-1:0];
								state_d   = S_WALK;
							end else begin
								fin = 1'b1;
							end
						end
						REQ_GET: begin
							mem_raddr = cl_w[AW-1:0];
							state_d   = S_GET;
						end
						REQ_PUT: begin
							mem_we    = cl_ok;
							mem_waddr = cl_w[AW-1:0];
							mem_wdata = entry_value;
							fin       = 1'b1;
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end

			S_TAIL: begin
				if (tail_val == END_MARKER) begin
					scan_d  = 13'(scan_start);
					pend_d  = 1'b0;
					state_d = S_SCAN;
				end else begin
					fin            = 1'b1;
					fin_res.status = ST_NOT_END;
				end
			end

			S_SCAN: begin
				if (pend_s1 && (mem_rdata == '0)) begin
					mem_we    = 1'b1;
					mem_waddr = pend_w[AW-1:0];
					mem_wdata = END_MARKER;
					found_d   = pend_addr_s1;
					pend_d    = 1'b0;
					if (clst_q != '0) begin
						state_d = S_LINK;
					end else begin
						fin                 = 1'b1;
						fin_res.new_cluster = pend_addr_s1;
					end
				end else if (scan_q < lim) begin
					mem_raddr   = scan_w[AW-1:0];
					pend_d      = 1'b1;
					pend_addr_d = scan_q[CLUSTER_W-1:0];
					scan_d      = scan_q + 13'd1;
				end else begin
					pend_d         = 1'b0;
					fin            = 1'b1;
					fin_res.status = ST_NO_FREE;
				end
			end

			S_LINK: begin
				mem_we              = 1'b1;
				mem_waddr           = clq_w[AW-1:0];
				mem_wdata           = 32'(found_q);
				fin                 = 1'b1;
				fin_res.new_cluster = found_q;
			end

			S_PREV: begin
				if (prev_val != clq_w) begin
					fin            = 1'b1;
					fin_res.status = ST_PRED_BAD;
				end else begin
					mem_we    = pclq_ok;
					mem_waddr = pclq_w[AW-1:0];
					mem_wdata = END_MARKER;
					if (clq_ok) begin
						mem_raddr = clq_w[AW-1:0];
						walk_d    = clq_w[AW-1:0];
						state_d   = S_WALK;
					end else begin
						fin = 1'b1;
					end
				end
			end

			S_WALK: begin
				mem_we    = 1'b1;
				mem_waddr = walk_q;
				mem_wdata = '0;
				if ((mem_rdata == END_MARKER) || (mem_rdata == '0) || !nxt_ok) begin
					fin = 1'b1;
				end else begin
					mem_raddr = mem_rdata[AW-1:0];
					walk_d    = mem_rdata[AW-1:0];
				end
			end

			S_GET: begin
				fin                = 1'b1;
				fin_res.read_value = clq_ok ? mem_rdata : '0;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (fin) begin
			state_d = S_IDLE;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
